// ===== hw/rtl/llrb_pkg.sv =====
// shared constants, codes and types of the last-lines ring buffer
package llrb_pkg;

  // store geometry
  localparam int MAX_LINES   = 16;
  localparam int LINE_BYTES  = 1024;
  localparam int STORE_DEPTH = MAX_LINES * LINE_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = $clog2(LINE_BYTES);
  localparam int SLOT_W      = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int STEP_W      = $clog2(MAX_LINES + 1);

  // fixed field widths
  localparam int FUNC_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int LC_W      = 5;
  localparam int START_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  // function codes of an input word
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_LINE = 2'd2;

  // register reset values
  localparam logic [LC_W-1:0]    LINE_COUNT_RESET = 5'd10;
  localparam logic [START_W-1:0] START_LINE_RESET = 16'd1;

  // command queue geometry
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // commands handed from front to back
  typedef enum logic [2:0] {
    CMD_PUSH,   // store a byte in keep mode
    CMD_READ,   // give the next drained byte
    CMD_CLEAR,  // start a new stream
    CMD_PASS,   // pass a byte straight out
    CMD_NONE    // answer a read with nothing left
  } cmd_e;

  typedef struct packed {
    cmd_e              op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

endpackage

// ===== hw/rtl/llrb_front.sv =====
// front end: accepts input words, handles pass-through skipping, issues commands
module llrb_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [llrb_pkg::FUNC_W-1:0]    func_i,
  input  logic [llrb_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                           cfg_we_i,
  input  logic [llrb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [llrb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output llrb_pkg::cmd_t                 q_cmd_o
);

  logic                               mode_q;
  logic [llrb_pkg::START_W-1:0]       start_q;
  logic [llrb_pkg::START_W-1:0]       skip_q, skip_d;
  logic                               accept;

  // lines to skip before passing: start line minus one, none for zero
  function automatic logic [llrb_pkg::START_W-1:0] skip_reload(
    input logic [llrb_pkg::START_W-1:0] s
  );
    logic [llrb_pkg::START_W-1:0] r;
    r = (s == '0) ? '0 : s - 1'b1;
    return r;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // classify the word
  always_comb begin
    skip_d          = skip_q;
    q_push_o        = 1'b0;
    q_cmd_o.op      = llrb_pkg::CMD_PUSH;
    q_cmd_o.data    = data_byte_i;
    if (accept) begin
      unique case (func_i)
        llrb_pkg::FUNC_PUSH: begin
          if (mode_q) begin
            if (skip_q != '0) begin
              if (data_byte_i == llrb_pkg::NEWLINE) begin
                skip_d = skip_q - 1'b1;
              end
            end else begin
              q_push_o   = 1'b1;
              q_cmd_o.op = llrb_pkg::CMD_PASS;
            end
          end else begin
            q_push_o   = 1'b1;
            q_cmd_o.op = llrb_pkg::CMD_PUSH;
          end
        end
        llrb_pkg::FUNC_READ: begin
          q_push_o   = 1'b1;
          q_cmd_o.op = mode_q ? llrb_pkg::CMD_NONE : llrb_pkg::CMD_READ;
        end
        llrb_pkg::FUNC_CLEAR: begin
          q_push_o   = 1'b1;
          q_cmd_o.op = llrb_pkg::CMD_CLEAR;
          skip_d     = skip_reload(start_q);
        end
        default: begin
        end
      endcase
    end
    // line count and start line writes reload the skip count
    if (cfg_we_i && (cfg_idx_i == llrb_pkg::REG_LINE_COUNT)) begin
      skip_d = skip_reload(start_q);
    end
    if (cfg_we_i && (cfg_idx_i == llrb_pkg::REG_START_LINE)) begin
      skip_d = skip_reload(cfg_wdata_i[llrb_pkg::START_W-1:0]);
    end
  end

  // mode, start line and skip count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      start_q <= llrb_pkg::START_LINE_RESET;
      skip_q  <= skip_reload(llrb_pkg::START_LINE_RESET);
    end else begin
      if (cfg_we_i && (cfg_idx_i == llrb_pkg::REG_MODE)) begin
        mode_q <= cfg_wdata_i[0];
      end
      if (cfg_we_i && (cfg_idx_i == llrb_pkg::REG_START_LINE)) begin
        start_q <= cfg_wdata_i[llrb_pkg::START_W-1:0];
      end
      skip_q <= skip_d;
    end
  end

endmodule

// ===== hw/rtl/llrb_cmd_queue.sv =====
// short command queue between front and back
module llrb_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  llrb_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output llrb_pkg::cmd_t cmd_o,
  input  logic           pop_i
);

  llrb_pkg::cmd_t                ent_q [llrb_pkg::QDEPTH];
  logic [llrb_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
  logic [llrb_pkg::QCNT_W-1:0]   cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == llrb_pkg::QCNT_W'(llrb_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = ent_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == llrb_pkg::QPTR_W'(llrb_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == llrb_pkg::QPTR_W'(llrb_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/llrb_back.sv =====
// back end: line store, slot table, drain sequencer and output register
module llrb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [llrb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [llrb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           q_valid_i,
  input  llrb_pkg::cmd_t                 q_cmd_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [llrb_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                           is_last_o,
  output logic                           none_left_o
);

  localparam int SUM_W = llrb_pkg::STEP_W + 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_FETCH   = 2'd1;
  localparam logic [1:0] ST_DELIVER = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [llrb_pkg::LC_W-1:0]         lc_q;
  logic [llrb_pkg::STEP_W-1:0]       n_lines;
  logic [llrb_pkg::LEN_W-1:0]        slot_len_q [llrb_pkg::MAX_LINES];
  logic [llrb_pkg::LEN_W-1:0]        slot_len_d [llrb_pkg::MAX_LINES];
  logic [llrb_pkg::SLOT_W-1:0]       wslot_q, wslot_d, wslot_nxt;
  logic [llrb_pkg::LEN_W-1:0]        wpos_q, wpos_d;
  logic                              disc_q, disc_d;
  logic [llrb_pkg::STEP_W-1:0]       step_q, step_d;
  logic [llrb_pkg::LEN_W-1:0]        dpos_q, dpos_d;
  logic                              drain_q, drain_d;

  logic [SUM_W-1:0]                  slot_sum;
  logic [llrb_pkg::SLOT_W-1:0]       cur_slot;
  logic [llrb_pkg::LEN_W-1:0]        cur_len;
  logic                              cur_empty, at_end;

  logic [llrb_pkg::BYTE_W-1:0]       line_store_q [llrb_pkg::STORE_DEPTH];
  logic [llrb_pkg::BYTE_W-1:0]       rdata_q;
  logic                              mem_we, mem_re;
  logic [llrb_pkg::BYTE_W-1:0]       mem_wdata;
  logic [llrb_pkg::SLOT_W-1:0]       addr_slot;
  logic [llrb_pkg::LEN_W-1:0]        addr_pos;
  logic [llrb_pkg::ADDR_W-1:0]       mem_addr;

  logic                              out_valid_q;
  logic [llrb_pkg::BYTE_W-1:0]       out_byte_q;
  logic                              is_last_q, none_left_q;
  logic                              out_free, emit, emit_last, emit_none;
  logic [llrb_pkg::BYTE_W-1:0]       emit_byte;
  logic                              is_nl, is_long, do_clear;

  // lines kept, clamped to between one and the slot count
  always_comb begin
    if (lc_q == '0) begin
      n_lines = llrb_pkg::STEP_W'(1);
    end else if (int'(lc_q) > llrb_pkg::MAX_LINES) begin
      n_lines = llrb_pkg::STEP_W'(llrb_pkg::MAX_LINES);
    end else begin
      n_lines = llrb_pkg::STEP_W'(lc_q);
    end
  end

  // slot under the drain step, oldest first from the write slot
  assign slot_sum  = SUM_W'(wslot_q) + SUM_W'(step_q);
  assign cur_slot  = llrb_pkg::SLOT_W'((slot_sum >= SUM_W'(n_lines)) ?
                                       slot_sum - SUM_W'(n_lines) : slot_sum);
  assign cur_len   = slot_len_q[cur_slot];
  assign cur_empty = (cur_len == '0);
  assign at_end    = (step_q >= n_lines);

  assign wslot_nxt = ((llrb_pkg::STEP_W'(wslot_q) + 1'b1) >= n_lines) ? '0 : wslot_q + 1'b1;
  assign is_nl     = (q_cmd_i.data == llrb_pkg::NEWLINE);
  assign is_long   = (wpos_q >= llrb_pkg::LEN_W'(llrb_pkg::LINE_BYTES - 2));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign do_clear  = cfg_we_i && (cfg_idx_i == llrb_pkg::REG_LINE_COUNT);

  // command execution
  always_comb begin
    state_d    = state_q;
    wslot_d    = wslot_q;
    wpos_d     = wpos_q;
    disc_d     = disc_q;
    step_d     = step_q;
    dpos_d     = dpos_q;
    drain_d    = drain_q;
    slot_len_d = slot_len_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = llrb_pkg::NEWLINE;
    addr_slot  = cur_slot;
    addr_pos   = dpos_q;
    q_pop_o    = 1'b0;
    emit       = 1'b0;
    emit_byte  = '0;
    emit_last  = 1'b0;
    emit_none  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_cmd_i.op)
            llrb_pkg::CMD_PUSH: begin
              q_pop_o = 1'b1;
              if (!drain_q) begin
                if (disc_q) begin
                  // drop the rest of a cut line
                  if (is_nl) begin
                    disc_d = 1'b0;
                  end
                end else begin
                  mem_we    = 1'b1;
                  addr_slot = wslot_q;
                  addr_pos  = wpos_q;
                  if (is_nl || is_long) begin
                    // end of line, or cut: newline takes this place
                    mem_wdata           = llrb_pkg::NEWLINE;
                    slot_len_d[wslot_q] = wpos_q + 1'b1;
                    wslot_d             = wslot_nxt;
                    wpos_d              = '0;
                    disc_d              = !is_nl;
                  end else begin
                    mem_wdata = q_cmd_i.data;
                    wpos_d    = wpos_q + 1'b1;
                  end
                end
              end
            end
            llrb_pkg::CMD_READ: begin
              q_pop_o = 1'b1;
              if (!drain_q) begin
                // first read closes an open line with a newline
                if (wpos_q != '0) begin
                  mem_we              = 1'b1;
                  addr_slot           = wslot_q;
                  addr_pos            = wpos_q;
                  mem_wdata           = llrb_pkg::NEWLINE;
                  slot_len_d[wslot_q] = wpos_q + 1'b1;
                  wslot_d             = wslot_nxt;
                  wpos_d              = '0;
                end
                drain_d = 1'b1;
                step_d  = '0;
                dpos_d  = '0;
              end
              state_d = ST_FETCH;
            end
            llrb_pkg::CMD_CLEAR: begin
              q_pop_o    = 1'b1;
              slot_len_d = '{default: '0};
              wslot_d    = '0;
              wpos_d     = '0;
              disc_d     = 1'b0;
              step_d     = '0;
              dpos_d     = '0;
              drain_d    = 1'b0;
            end
            llrb_pkg::CMD_PASS: begin
              if (out_free) begin
                q_pop_o   = 1'b1;
                emit      = 1'b1;
                emit_byte = q_cmd_i.data;
              end
            end
            llrb_pkg::CMD_NONE: begin
              if (out_free) begin
                q_pop_o   = 1'b1;
                emit      = 1'b1;
                emit_none = 1'b1;
              end
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (at_end) begin
          // nothing left to give
          if (out_free) begin
            emit      = 1'b1;
            emit_none = 1'b1;
            state_d   = ST_IDLE;
          end
        end else if (cur_empty) begin
          step_d = step_q + 1'b1;
        end else begin
          mem_re = 1'b1;
          if ((dpos_q + 1'b1) >= cur_len) begin
            step_d = step_q + 1'b1;
            dpos_d = '0;
          end else begin
            dpos_d = dpos_q + 1'b1;
          end
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        // skip empty slots so the last-byte flag is known
        if (!at_end && cur_empty) begin
          step_d = step_q + 1'b1;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_byte = rdata_q;
          emit_last = at_end;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // writing the line count starts a new stream
    if (do_clear) begin
      slot_len_d = '{default: '0};
      wslot_d    = '0;
      wpos_d     = '0;
      disc_d     = 1'b0;
      step_d     = '0;
      dpos_d     = '0;
      drain_d    = 1'b0;
      state_d    = ST_IDLE;
    end
  end

  assign mem_addr = llrb_pkg::ADDR_W'(addr_slot) * llrb_pkg::ADDR_W'(llrb_pkg::LINE_BYTES)
                  + llrb_pkg::ADDR_W'(addr_pos);

  // line store, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_store_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= line_store_q[mem_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      lc_q       <= llrb_pkg::LINE_COUNT_RESET;
      slot_len_q <= '{default: '0};
      wslot_q    <= '0;
      wpos_q     <= '0;
      disc_q     <= 1'b0;
      step_q     <= '0;
      dpos_q     <= '0;
      drain_q    <= 1'b0;
    end else begin
      if (do_clear) begin
        lc_q <= cfg_wdata_i[llrb_pkg::LC_W-1:0];
      end
      state_q    <= state_d;
      slot_len_q <= slot_len_d;
      wslot_q    <= wslot_d;
      wpos_q     <= wpos_d;
      disc_q     <= disc_d;
      step_q     <= step_d;
      dpos_q     <= dpos_d;
      drain_q    <= drain_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      out_byte_q  <= emit_byte;
      is_last_q   <= emit_last;
      none_left_q <= emit_none;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_last_o   = is_last_q;
  assign none_left_o = none_left_q;

endmodule

// ===== hw/rtl/last_lines_ring_buffer.sv =====
// top level of the last-lines ring buffer
// Takes one text byte (or a read or clear request) per input word and keeps the
// last line_count lines in a ring of 16 slots of 1024 bytes, or in pass-through
// mode returns pushed bytes once start_line-1 lines are skipped. The front takes
// a word in every cycle while its two-entry command queue has room; the back
// runs one command at a time: a read goes through the single-port line store
// (address, registered read data, delivery) and steps over each empty slot it
// meets. Results wait in an output register; while a stalled output holds it, a
// command that gives a result waits in the back, and once the queue behind it is
// full the front stalls too. Keep-mode pushes and clears give no result and go
// on under a stalled output. The line store needs no clearing pass after reset:
// only written bytes are ever read back.
module last_lines_ring_buffer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [llrb_pkg::FUNC_W-1:0]    func_i,
  input  logic [llrb_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [llrb_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                           is_last_o,
  output logic                           none_left_o,
  input  logic                           cfg_we_i,
  input  logic [llrb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [llrb_pkg::CFG_W-1:0]     cfg_wdata_i
);

  logic           q_full, q_push, q_valid, q_pop;
  llrb_pkg::cmd_t q_cmd_in, q_cmd_out;

  // accept and classify
  llrb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in)
  );

  // command queue
  llrb_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out),
    .pop_i   (q_pop)
  );

  // store, drain and output
  llrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .is_last_o   (is_last_o),
    .none_left_o (none_left_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// testbench of the last-lines ring buffer: directed and random stream words checked against a tail predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import llrb_pkg::*;

  // func value with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_CYCLES  = 48;
  localparam int RANDOM_WORDS  = 400;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data;
  } stream_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_last;
    logic              none_left;
  } reply_t;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func      = '0;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 is_last;
  logic                 none_left;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  last_lines_ring_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .is_last_o   (is_last),
    .none_left_o (none_left),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // words waiting to be sent and replies still owed by the block
  stream_word_t word_queue[$];
  reply_t       replies_due[$];
  int           words_queued = 0;
  int           mismatches   = 0;

  // tail state as the block should hold it
  logic [BYTE_W-1:0]  line_mem [0:STORE_DEPTH-1];
  logic [10:0]        slot_len [0:MAX_LINES-1];
  logic [SLOT_W-1:0]  head_slot;
  logic [10:0]        fill_pos;
  logic               dropping;
  logic [START_W-1:0] lines_to_skip;
  logic [STEP_W-1:0]  drain_step;
  logic [10:0]        drain_off;
  logic               draining;
  logic [LC_W-1:0]    cfg_line_count;
  logic               cfg_pass_mode;
  logic [START_W-1:0] cfg_start_line;

  // number of slots in use, line count clamped
  function automatic int kept_lines();
    if (cfg_line_count < 1) return 1;
    if (cfg_line_count > MAX_LINES) return MAX_LINES;
    return int'(cfg_line_count);
  endfunction

  function automatic void reload_skip();
    lines_to_skip = (cfg_start_line == 0) ? '0 : cfg_start_line - 1'b1;
  endfunction

  function automatic void restart_stream();
    foreach (slot_len[i]) slot_len[i] = '0;
    head_slot  = '0;
    fill_pos   = '0;
    dropping   = 1'b0;
    drain_step = '0;
    drain_off  = '0;
    draining   = 1'b0;
    reload_skip();
  endfunction

  function automatic int ring_slot(int step);
    return (int'(head_slot) + step) % kept_lines();
  endfunction

  // finish the line being written and move to the next slot
  function automatic void close_line(int len);
    slot_len[head_slot] = 11'(len);
    head_slot = (int'(head_slot) + 1 >= kept_lines()) ? '0 : head_slot + 1'b1;
    fill_pos  = '0;
  endfunction

  function automatic void step_over_empty();
    while (drain_step < kept_lines() && slot_len[ring_slot(int'(drain_step))] == 0)
      drain_step++;
  endfunction

  // advance the tail state by one word, queue the reply it causes
  function automatic void work_out_reply(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b);
    reply_t r;
    int     n;
    int     s;
    int     base;
    r    = '0;
    n    = kept_lines();
    base = int'(head_slot) * LINE_BYTES;
    case (f)
      FUNC_CLEAR: restart_stream();
      FUNC_PUSH: begin
        if (cfg_pass_mode) begin
          if (lines_to_skip > 0) begin
            if (b == NEWLINE) lines_to_skip--;
          end else begin
            r.out_byte = b;
            replies_due.push_back(r);
          end
        end else if (!draining) begin
          if (dropping) begin
            if (b == NEWLINE) dropping = 1'b0;
          end else if (b == NEWLINE) begin
            line_mem[base + int'(fill_pos)] = NEWLINE;
            close_line(int'(fill_pos) + 1);
          end else if (fill_pos >= LINE_BYTES - 2) begin
            // overlong line: cut it and drop the rest up to its newline
            line_mem[base + LINE_BYTES - 2] = NEWLINE;
            close_line(LINE_BYTES - 1);
            dropping = 1'b1;
          end else begin
            line_mem[base + int'(fill_pos)] = b;
            fill_pos++;
          end
        end
      end
      FUNC_READ: begin
        if (cfg_pass_mode) begin
          r.none_left = 1'b1;
        end else begin
          // first read closes an open last line
          if (!draining) begin
            if (fill_pos > 0) begin
              line_mem[base + int'(fill_pos)] = NEWLINE;
              close_line(int'(fill_pos) + 1);
            end
            draining   = 1'b1;
            drain_step = '0;
            drain_off  = '0;
          end
          step_over_empty();
          if (drain_step >= n) begin
            r.none_left = 1'b1;
          end else begin
            s = ring_slot(int'(drain_step));
            r.out_byte = line_mem[s * LINE_BYTES + int'(drain_off)];
            drain_off++;
            if (drain_off >= slot_len[s]) begin
              drain_step++;
              drain_off = '0;
            end
            step_over_empty();
            r.is_last = (drain_step >= n);
          end
        end
        replies_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // any byte but a newline
  function automatic logic [BYTE_W-1:0] rand_char();
    logic [BYTE_W-1:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == NEWLINE) ? 8'h0B : c;
  endfunction

  task automatic add_word(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] d, bit counts);
    stream_word_t w;
    w.func = f;
    w.data = d;
    word_queue.push_back(w);
    if (counts) words_queued++;
  endtask

  task automatic push_text(string txt);
    for (int i = 0; i < txt.len(); i++) add_word(FUNC_PUSH, txt[i], 1'b1);
  endtask

  task automatic push_line(int len, bit closed);
    for (int i = 0; i < len; i++) add_word(FUNC_PUSH, rand_char(), 1'b1);
    if (closed) add_word(FUNC_PUSH, NEWLINE, 1'b1);
  endtask

  // register write; the block is idle, so the shadow copy is updated at once
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_LINE_COUNT: begin
        cfg_line_count = value[LC_W-1:0];
        restart_stream();
      end
      REG_MODE: cfg_pass_mode = value[0];
      REG_START_LINE: begin
        cfg_start_line = value[START_W-1:0];
        reload_skip();
      end
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // wait until every word is taken and every reply is back, then let the block settle
  task automatic wait_quiet();
    while (word_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // input driver with random gaps between words
  stream_word_t next_word;
  int           in_gap  = 0;
  int           in_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      func      <= '0;
      data_byte <= '0;
      in_gap    = 0;
    end else begin
      if (in_valid && !in_stall) begin
        work_out_reply(func, data_byte);
        if (in_calm > 0) begin
          in_calm--;
          in_gap = 0;
        end else begin
          in_gap = pick_pause();
          if ($urandom_range(0, 99) < 2) in_calm = $urandom_range(20, 80);
        end
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (word_queue.size() != 0) begin
        next_word = word_queue.pop_front();
        in_valid  <= 1'b1;
        func      <= next_word.func;
        data_byte <= next_word.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor with random stalls
  reply_t want;
  int     out_hold = 0;
  int     out_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("unexpected word: out_byte %0h is_last %0b none_left %0b",
                 out_byte, is_last, none_left);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
            mismatches++;
          end
          if (is_last !== want.is_last) begin
            $error("is_last: expected %0b, got %0b", want.is_last, is_last);
            mismatches++;
          end
          if (none_left !== want.none_left) begin
            $error("none_left: expected %0b, got %0b", want.none_left, none_left);
            mismatches++;
          end
        end
      end
      if (out_calm > 0) begin
        out_calm--;
        out_stall <= 1'b0;
      end else if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 99) < 2) out_calm = $urandom_range(20, 80);
        else if ($urandom_range(0, 2) == 0) out_hold = pick_pause();
      end
    end
  end

  // stimulus
  initial begin
    int          random_from;
    int          keep_n;
    int          lines;
    int          len;
    int          reads;
    int          bytes_kept;
    int          r;
    int          lens[$];
    logic [15:0] value;

    cfg_line_count = LINE_COUNT_RESET;
    cfg_pass_mode  = 1'b0;
    cfg_start_line = START_LINE_RESET;
    restart_stream();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty line, byte extremes, open last line, push while draining,
    // unused func, read past the end, read of an empty store
    write_reg(REG_LINE_COUNT, 16'd3);
    write_reg(REG_MODE, 16'd0);
    write_reg(REG_START_LINE, 16'd1);
    push_text("ab\n\n");
    add_word(FUNC_PUSH, 8'h00, 1'b1);
    add_word(FUNC_PUSH, 8'hFF, 1'b1);
    push_text("\nxy");
    add_word(FUNC_UNUSED, 8'hA5, 1'b0);
    repeat (4) add_word(FUNC_READ, 8'h00, 1'b1);
    add_word(FUNC_PUSH, 8'h41, 1'b0);
    repeat (4) add_word(FUNC_READ, 8'hFF, 1'b1);
    add_word(FUNC_CLEAR, 8'h5A, 1'b1);
    add_word(FUNC_READ, 8'h00, 1'b1);
    wait_quiet();

    // directed: pass-through skipping the first line, read in that mode
    write_reg(REG_MODE, 16'd1);
    write_reg(REG_START_LINE, 16'd2);
    push_text("a\nb");
    add_word(FUNC_READ, 8'h00, 1'b1);
    wait_quiet();

    // one slot, a line around the cut length: kept whole if it ends in time,
    // else cut with its rest dropped; drained to the end
    write_reg(REG_LINE_COUNT, 16'hFFE1);
    write_reg(REG_MODE, 16'hFFFE);
    add_word(FUNC_CLEAR, 8'h00, 1'b1);
    push_line($urandom_range(LINE_BYTES - 2, LINE_BYTES + 3), 1'b1);
    repeat (LINE_BYTES + 1) add_word(FUNC_READ, 8'($urandom), 1'b1);
    wait_quiet();

    // random phases, each under its own register setting
    random_from = words_queued;
    while (words_queued - random_from < RANDOM_WORDS) begin
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       value = 16'd1;
          1:       value = 16'd16;
          2:       value = 16'd0;
          3:       value = 16'd31;
          default: value = 16'($urandom_range(1, 16));
        endcase
        if ($urandom_range(0, 1) == 1) value[15:5] = 11'($urandom);
        write_reg(REG_LINE_COUNT, value);
      end
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0:       value = 16'd0;
          1:       value = 16'd1;
          2:       value = 16'hFFFF;
          3:       value = 16'($urandom);
          default: value = 16'($urandom_range(2, 4));
        endcase
        write_reg(REG_START_LINE, value);
      end
      value    = 16'($urandom);
      value[0] = ($urandom_range(0, 3) == 0);
      write_reg(REG_MODE, value);
      keep_n = kept_lines();

      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          // noise: any func, bytes rich in newlines
          repeat ($urandom_range(4, 24)) begin
            r = $urandom_range(0, 3);
            add_word(2'(r), ($urandom_range(0, 3) == 0) ? NEWLINE : 8'($urandom),
                     r != FUNC_UNUSED);
          end
        end else if (cfg_pass_mode) begin
          if ($urandom_range(0, 2) == 0) add_word(FUNC_CLEAR, 8'($urandom), 1'b1);
          repeat ($urandom_range(10, 60)) begin
            r = $urandom_range(0, 9);
            if (r == 0) add_word(FUNC_READ, 8'($urandom), 1'b1);
            else if (r < 3) add_word(FUNC_PUSH, NEWLINE, 1'b1);
            else add_word(FUNC_PUSH, 8'($urandom), 1'b1);
          end
        end else begin
          // well-formed tail: lines, maybe an open last line, then a full drain
          if ($urandom_range(0, 4) != 0) add_word(FUNC_CLEAR, 8'($urandom), 1'b1);
          lens.delete();
          lines = $urandom_range(0, keep_n + 3);
          repeat (lines) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
            push_line(len, 1'b1);
            lens.push_back(len + 1);
          end
          if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(1, 8);
            push_line(len, 1'b0);
            lens.push_back(len + 1);
          end
          bytes_kept = 0;
          for (int i = lens.size() - 1; i >= 0 && i >= lens.size() - keep_n; i--)
            bytes_kept += lens[i];
          reads = bytes_kept + $urandom_range(0, 2);
          repeat (reads) begin
            if ($urandom_range(0, 15) == 0) add_word(FUNC_PUSH, 8'($urandom), 1'b0);
            add_word(FUNC_READ, 8'($urandom), 1'b1);
          end
        end
      end
      wait_quiet();
    end

    wait_quiet();
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
